/* design/per_client_token_bucket_policer_macros.svh */
// ----------------------------------------------------------------------------
// Policer assertion macros
// Concurrent check helpers, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_TOKEN_BUCKET_POLICER_MACROS_SVH
`define PER_CLIENT_TOKEN_BUCKET_POLICER_MACROS_SVH

`ifndef SYNTHESIS
`define PCTBP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("policer check failed");
`define PCTBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("policer check failed");
`else
`define PCTBP_ASSERT_SAME(lbl, ante, cons)
`define PCTBP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/pctbp_pkg.sv */
// ----------------------------------------------------------------------------
// Policer package
// Table sizes, constants, entry layout and controller states.
// ----------------------------------------------------------------------------
package pctbp_pkg;

  localparam int CLIENTS   = 512;
  localparam int RATE_BITS = 34;
  localparam int IDX_W     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CNT_W     = $clog2(CLIENTS + 1);

  localparam int RATE_W = 34;
  localparam int DIV_W  = 30;
  localparam int Q_W    = 34;

  // reciprocals for the constant divisions, both rounded down
  localparam int RCP_W       = 33;
  localparam int SEC_SHIFT   = 32;
  localparam int BURST_SHIFT = 35;

  localparam logic [RATE_W-1:0] RATE_MASK =
    RATE_W'((35'd1 << RATE_BITS) - 35'd1);
  localparam logic [DIV_W-1:0] NS_PER_SECOND = 30'd1000000000;
  localparam logic [DIV_W-1:0] BURST_DIVISOR = 30'd10;
  localparam logic [RCP_W-1:0] RECIP_SECOND  = 33'd4611686018;
  localparam logic [RCP_W-1:0] RECIP_BURST   = 33'd3435973836;
  localparam logic [7:0]       TOS_ECN_MASK  = 8'h03;
  localparam logic [3:0]       IPV4_VERSION  = 4'd4;

  typedef struct packed {
    logic [5:0]        dscp;
    logic [63:0]       last;
    logic [RATE_W-1:0] tokens;
    logic [RATE_W-1:0] rate;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSTALL,
    ST_DREAD,
    ST_DLOAD,
    ST_MUL,
    ST_FILL_GO,
    ST_FILL_WAIT,
    ST_BURST_GO,
    ST_BURST_WAIT,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_EST,
    DV_BACK,
    DV_FIX
  } div_state_t;

endpackage

/* design/pctbp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pctbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/pctbp_div.sv */
// ----------------------------------------------------------------------------
// Constant-divisor divider
// Quotient estimate by reciprocal multiplication, then compare-and-subtract
// steps until the remainder is below the divisor (one second or ten).
// ----------------------------------------------------------------------------
module pctbp_div
  import pctbp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           burst_sel,
  input  logic [63:0]    dividend,
  output logic           done,
  output logic [Q_W-1:0] quotient
);

  div_state_t dstate, dstate_next;

  logic                   sel;
  logic [63:0]            x;
  logic [63:0]            rem;
  logic [Q_W-1:0]         q;
  logic [Q_W-1:0]         est_a;
  logic [RCP_W-1:0]       recip;
  logic [DIV_W-1:0]       dvs;
  logic [Q_W+RCP_W-1:0]   est_p;
  logic [Q_W-1:0]         q_est;
  logic [Q_W+DIV_W-1:0]   back;
  logic                   fits;

  // the estimate never exceeds the true quotient
  assign est_a = sel ? x[Q_W-1:0] : x[63:64-Q_W];
  assign recip = sel ? RECIP_BURST : RECIP_SECOND;
  assign dvs   = sel ? BURST_DIVISOR : NS_PER_SECOND;
  assign est_p = est_a * recip;
  assign q_est = sel ? Q_W'(est_p[Q_W+RCP_W-1:BURST_SHIFT])
                     : est_p[SEC_SHIFT+Q_W-1:SEC_SHIFT];
  assign back  = q * dvs;
  assign fits  = (rem >= 64'(dvs));

  always_comb begin
    dstate_next = dstate;
    unique case (dstate)
      DV_IDLE: dstate_next = start ? DV_EST : DV_IDLE;
      DV_EST:  dstate_next = DV_BACK;
      DV_BACK: dstate_next = DV_FIX;
      DV_FIX:  dstate_next = fits ? DV_FIX : DV_IDLE;
      default: dstate_next = DV_IDLE;
    endcase
  end

  always_comb begin
    done     = (dstate == DV_FIX) && !fits;
    quotient = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= DV_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= dividend;
      sel <= burst_sel;
    end
    if (dstate == DV_EST) begin
      q <= q_est;
    end
    if (dstate == DV_BACK) begin
      rem <= x - back;
    end
    if (dstate == DV_FIX && fits) begin
      // take one more divisor off the remainder
      rem <= rem - 64'(dvs);
      q   <= q + Q_W'(1);
    end
  end

endmodule

/* design/per_client_token_bucket_policer.sv */
// ----------------------------------------------------------------------------
// Per-client token bucket policer
// Client table lookup, DSCP remark and token bucket policing per packet.
// ----------------------------------------------------------------------------
// One item is in work at a time; busy is high from the start transfer until
// the result strobe, and the next item can be taken in the cycle after it. A
// packet without a complete version 4 header skips the table and has its
// result in the cycle after the transfer. Otherwise the key memory is searched
// one installed entry per cycle until the key is found or every installed
// client has been read. A rule write then passes through an install state.
// A matched packet reads its entry and, with a nonzero rate, goes on to the
// multiply and two divisions by constants (refill over one second, burst as
// rate / 10), each a reciprocal estimate followed by compare-and-subtract
// steps. The strobe cycle follows. The result appears for one cycle with done
// high and cannot be held off. No clearing pass is needed after reset: clients
// fill the table from slot 0 upwards and a fill count marks the end.
// ----------------------------------------------------------------------------
`include "per_client_token_bucket_policer_macros.svh"

module per_client_token_bucket_policer
  import pctbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] client_ip,
  input  logic [63:0] timestamp_ns,
  input  logic        header_complete,
  input  logic [3:0]  ip_version,
  input  logic [7:0]  tos_in,
  input  logic [15:0] packet_length,
  input  logic [33:0] rule_rate,
  input  logic [5:0]  rule_dscp,
  input  logic [33:0] rule_tokens,
  output logic        done,
  output logic        verdict,
  output logic [7:0]  tos_out,
  output logic        tos_rewritten,
  output logic        rule_matched,
  output logic        table_full
);

  state_t state, state_next;

  // captured item
  logic              it_kind;
  logic [31:0]       it_ip;
  logic [63:0]       it_now;
  logic [15:0]       it_len;
  logic [RATE_W-1:0] it_rate;
  logic [5:0]        it_dscp;
  logic [RATE_W-1:0] it_tokens;

  logic [CNT_W-1:0]  fill_cnt;
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic [IDX_W-1:0]  slot;
  logic [DIV_W-1:0]  elapsed;
  logic [63:0]       product;
  logic [Q_W-1:0]    q_fill;
  logic [Q_W-1:0]    burst;

  logic              accept;
  logic              issue;
  logic              hit;
  logic              miss;

  logic              key_we, key_re;
  logic [31:0]       key_rdata;
  logic              dat_we, dat_re;
  logic [IDX_W-1:0]  dat_waddr;
  entry_t            dat_wdata, ent;

  logic              div_start, div_done;
  logic              div_sel;
  logic [63:0]       div_dividend;
  logic [Q_W-1:0]    div_q;

  logic [63:0]       diff;
  logic [63:0]       prod_c;
  logic [RATE_W:0]   fill;
  logic [RATE_W-1:0] capped;
  logic              short;
  logic [7:0]        new_tos;

  assign accept = start && !busy;
  assign issue  = (state == ST_SCAN) && (scan_idx < fill_cnt);
  assign hit    = (state == ST_SCAN) && cmp_vld && (key_rdata == it_ip);
  assign miss   = (state == ST_SCAN) && !cmp_vld && !issue;

  pctbp_ram #(.WIDTH(32), .DEPTH(CLIENTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot),
    .wdata (it_ip),
    .re    (key_re),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  pctbp_ram #(.WIDTH($bits(entry_t)), .DEPTH(CLIENTS)) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .re    (dat_re),
    .raddr (slot),
    .rdata (ent)
  );

  pctbp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .burst_sel (div_sel),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_q)
  );

  // datapath terms
  assign diff    = it_now - ent.last;
  assign prod_c  = ent.rate * elapsed;
  assign fill    = {1'b0, ent.tokens} + {1'b0, q_fill};
  assign capped  = (fill > {1'b0, burst}) ? burst : fill[RATE_W-1:0];
  assign short   = capped < {18'd0, it_len};
  assign new_tos = {ent.dscp, tos_out[1:0]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!kind && !(header_complete && ip_version == IPV4_VERSION)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = it_kind ? ST_INSTALL : ST_DREAD;
        end else if (miss) begin
          if (it_kind && (fill_cnt < CNT_W'(CLIENTS))) begin
            state_next = ST_INSTALL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_INSTALL:    state_next = ST_DONE;
      ST_DREAD:      state_next = ST_DLOAD;
      ST_DLOAD:      state_next = (ent.rate == '0) ? ST_DONE : ST_MUL;
      ST_MUL:        state_next = ST_FILL_GO;
      ST_FILL_GO:    state_next = ST_FILL_WAIT;
      ST_FILL_WAIT:  state_next = div_done ? ST_BURST_GO : ST_FILL_WAIT;
      ST_BURST_GO:   state_next = ST_BURST_WAIT;
      ST_BURST_WAIT: state_next = div_done ? ST_UPDATE : ST_BURST_WAIT;
      ST_UPDATE:     state_next = ST_DONE;
      ST_DONE:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy         = (state != ST_IDLE);
    done         = (state == ST_DONE);
    key_re       = issue;
    key_we       = (state == ST_INSTALL);
    dat_re       = (state == ST_DREAD);
    dat_we       = (state == ST_INSTALL) || (state == ST_UPDATE);
    dat_waddr    = slot;
    div_start    = (state == ST_FILL_GO) || (state == ST_BURST_GO);
    div_sel      = (state == ST_BURST_GO);
    div_dividend = (state == ST_BURST_GO) ? 64'(ent.rate) : product;
    if (state == ST_INSTALL) begin
      dat_wdata.dscp   = it_dscp;
      dat_wdata.last   = it_now;
      dat_wdata.tokens = it_tokens;
      dat_wdata.rate   = it_rate;
    end else begin
      dat_wdata.dscp   = ent.dscp;
      dat_wdata.last   = it_now;
      dat_wdata.tokens = short ? capped : RATE_W'(capped - {18'd0, it_len});
      dat_wdata.rate   = ent.rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill_cnt <= '0;
      cmp_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= issue && !hit;
      if (state == ST_INSTALL && !rule_matched) begin
        fill_cnt <= fill_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_kind       <= kind;
      it_ip         <= client_ip;
      it_now        <= timestamp_ns;
      it_len        <= packet_length;
      it_rate       <= rule_rate & RATE_MASK;
      it_dscp       <= rule_dscp;
      it_tokens     <= rule_tokens & RATE_MASK;
      scan_idx      <= '0;
      verdict       <= 1'b0;
      tos_out       <= kind ? 8'd0 : tos_in;
      tos_rewritten <= 1'b0;
      rule_matched  <= 1'b0;
      table_full    <= 1'b0;
    end
    if (issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
      cmp_idx  <= scan_idx[IDX_W-1:0];
    end
    if (hit) begin
      slot         <= cmp_idx;
      rule_matched <= 1'b1;
    end else if (miss) begin
      slot <= fill_cnt[IDX_W-1:0];
      if (it_kind && !(fill_cnt < CNT_W'(CLIENTS))) begin
        table_full <= 1'b1;
      end
    end
    if (state == ST_DLOAD) begin
      // remark keeps the ECN bits
      if (ent.dscp != '0 && new_tos != tos_out) begin
        tos_out       <= new_tos;
        tos_rewritten <= 1'b1;
      end
      elapsed <= (diff > 64'(NS_PER_SECOND)) ? NS_PER_SECOND : diff[DIV_W-1:0];
    end
    if (state == ST_MUL) begin
      product <= prod_c;
    end
    if (state == ST_FILL_WAIT && div_done) begin
      q_fill <= div_q;
    end
    if (state == ST_BURST_WAIT && div_done) begin
      burst <= div_q;
    end
    if (state == ST_UPDATE) begin
      verdict <= short;
    end
  end

  `PCTBP_ASSERT_NEXT(a_accept_busy, accept, busy)
  `PCTBP_ASSERT_NEXT(a_done_single, done, !done)
  `PCTBP_ASSERT_SAME(a_full_excl, done && table_full, !rule_matched && !verdict)
  `PCTBP_ASSERT_SAME(a_fill_bound, 1'b1, fill_cnt <= CNT_W'(CLIENTS))

endmodule

/* dv/per_client_token_bucket_policer_chk.sv */
// ----------------------------------------------------------------------------
// Policer scoreboard
// Watches start and done transfers on the policer, keeps its own copy of the
// client table, works out each result and compares it field by field.
// ----------------------------------------------------------------------------
module per_client_token_bucket_policer_chk
  import pctbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        kind,
  input  logic [31:0] client_ip,
  input  logic [63:0] timestamp_ns,
  input  logic        header_complete,
  input  logic [3:0]  ip_version,
  input  logic [7:0]  tos_in,
  input  logic [15:0] packet_length,
  input  logic [33:0] rule_rate,
  input  logic [5:0]  rule_dscp,
  input  logic [33:0] rule_tokens,
  input  logic        done,
  input  logic        verdict,
  input  logic [7:0]  tos_out,
  input  logic        tos_rewritten,
  input  logic        rule_matched,
  input  logic        table_full,
  output int          failures,
  output int          outstanding,
  output int          drops,
  output int          remarks,
  output int          refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       verdict;
    logic [7:0] tos;
    logic       rewritten;
    logic       matched;
    logic       full;
  } policer_result_t;

  logic              cl_valid [CLIENTS];
  logic [31:0]       cl_key   [CLIENTS];
  logic [RATE_W-1:0] cl_rate  [CLIENTS];
  logic [RATE_W-1:0] cl_tokens[CLIENTS];
  logic [63:0]       cl_last  [CLIENTS];
  logic [5:0]        cl_dscp  [CLIENTS];

  policer_result_t expected_results[$];

  assign outstanding = expected_results.size();

  function automatic int lookup_client(logic [31:0] key);
    for (int i = 0; i < CLIENTS; i++)
      if (cl_valid[i] && cl_key[i] == key) return i;
    return -1;
  endfunction

  task automatic police_item(output policer_result_t r);
    int idx;
    logic [63:0] elapsed, fill, burst;
    logic [7:0] nt;
    r = '0;
    if (kind) begin
      idx = lookup_client(client_ip);
      if (idx >= 0) r.matched = 1'b1;
      else begin
        for (int i = 0; i < CLIENTS; i++)
          if (!cl_valid[i]) begin
            idx = i;
            break;
          end
        if (idx < 0) r.full = 1'b1;
      end
      if (idx >= 0) begin
        cl_valid[idx]  = 1'b1;
        cl_key[idx]    = client_ip;
        cl_rate[idx]   = rule_rate;
        cl_tokens[idx] = rule_tokens;
        cl_last[idx]   = timestamp_ns;
        cl_dscp[idx]   = rule_dscp;
      end
    end else begin
      r.tos = tos_in;
      idx = (header_complete && ip_version == 4'd4) ? lookup_client(client_ip) : -1;
      if (idx >= 0) begin
        r.matched = 1'b1;
        if (cl_dscp[idx] != 6'd0) begin
          nt = (tos_in & 8'h03) | {cl_dscp[idx], 2'b00};
          if (nt != tos_in) begin
            r.tos = nt;
            r.rewritten = 1'b1;
          end
        end
        if (cl_rate[idx] != '0) begin
          burst = 64'(cl_rate[idx]) / 64'd10;
          elapsed = timestamp_ns - cl_last[idx];
          if (elapsed > 64'd1000000000) elapsed = 64'd1000000000;
          fill = 64'(cl_tokens[idx]) + (64'(cl_rate[idx]) * elapsed) / 64'd1000000000;
          if (fill > burst) fill = burst;
          if (fill < 64'(packet_length)) begin
            r.verdict = 1'b1;
            cl_tokens[idx] = fill[RATE_W-1:0];
          end else begin
            cl_tokens[idx] = RATE_W'(fill - 64'(packet_length));
          end
          cl_last[idx] = timestamp_ns;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    policer_result_t e, p;
    if (rst) begin
      for (int i = 0; i < CLIENTS; i++) cl_valid[i] = 1'b0;
      expected_results.delete();
    end else begin
      // compare first so a result and a new transfer on one edge stay ordered
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding");
          failures++;
        end else begin
          e = expected_results.pop_front();
          if (verdict !== e.verdict) begin
            $error("verdict: expected %0d, got %0d", e.verdict, verdict);
            failures++;
          end
          if (tos_out !== e.tos) begin
            $error("tos_out: expected %0h, got %0h", e.tos, tos_out);
            failures++;
          end
          if (tos_rewritten !== e.rewritten) begin
            $error("tos_rewritten: expected %0d, got %0d", e.rewritten, tos_rewritten);
            failures++;
          end
          if (rule_matched !== e.matched) begin
            $error("rule_matched: expected %0d, got %0d", e.matched, rule_matched);
            failures++;
          end
          if (table_full !== e.full) begin
            $error("table_full: expected %0d, got %0d", e.full, table_full);
            failures++;
          end
          drops += e.verdict;
          remarks += e.rewritten;
          refusals += e.full;
        end
      end
      if (start && !busy) begin
        police_item(p);
        expected_results.push_back(p);
      end
    end
  end

  final_check: assert property (@(posedge clk) 1'b1);
endmodule

/* dv/per_client_token_bucket_policer_tb.sv */
// ----------------------------------------------------------------------------
// Policer testbench
// Directed cases, then random rule writes and packets over a small client
// pool, then the table is filled to capacity; a scoreboard checks results.
// ----------------------------------------------------------------------------
module per_client_token_bucket_policer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst, start, busy, kind, header_complete, done;
  logic [31:0] client_ip;
  logic [63:0] timestamp_ns;
  logic [3:0]  ip_version;
  logic [7:0]  tos_in, tos_out;
  logic [15:0] packet_length;
  logic [33:0] rule_rate, rule_tokens;
  logic [5:0]  rule_dscp;
  logic        verdict, tos_rewritten, rule_matched, table_full;
  int          failures, outstanding, drops, remarks, refusals;
  int          cycles, n_writes, n_packets;
  logic [63:0] now_ns;

  localparam int          CYCLE_LIMIT = 5000000;
  localparam logic [31:0] POOL_BASE   = 32'hC0A8_0100;
  localparam logic [31:0] FILL_BASE   = 32'h0A00_0000;

  per_client_token_bucket_policer dut (.*);

  per_client_token_bucket_policer_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("per_client_token_bucket_policer_tb NOT OK");
      $finish;
    end
  end

  // transfer one item; called and returns at a falling edge
  task automatic transfer(input logic k, input logic [31:0] ip, input logic [63:0] ts,
                          input logic hdr, input logic [3:0] ver, input logic [7:0] tos,
                          input logic [15:0] len, input logic [33:0] rate,
                          input logic [5:0] dscp, input logic [33:0] tok);
    int gap;
    kind = k; client_ip = ip; timestamp_ns = ts; header_complete = hdr;
    ip_version = ver; tos_in = tos; packet_length = len; rule_rate = rate;
    rule_dscp = dscp; rule_tokens = tok;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (k) n_writes++;
    else n_packets++;
    gap = ($urandom_range(0, 9) < 4) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 300);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_rule(input logic [31:0] ip, input logic [33:0] rate,
                            input logic [5:0] dscp, input logic [33:0] tok);
    transfer(1'b1, ip, now_ns, 1'($urandom), 4'($urandom), 8'($urandom), 16'($urandom),
             rate, dscp, tok);
  endtask

  task automatic send_packet(input logic [31:0] ip, input logic [7:0] tos,
                             input logic [15:0] len);
    transfer(1'b0, ip, now_ns, 1'b1, 4'd4, tos, len, 34'({$urandom, $urandom}),
             6'($urandom), 34'({$urandom, $urandom}));
  endtask

  function automatic logic [33:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 34'($urandom_range(1, 1000));
      2: return 34'($urandom_range(1000, 50000000));
      3: return '1;
      default: return 34'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 64));
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(20, 1500));
    endcase
  endfunction

  task automatic advance_clock_ns();
    case ($urandom_range(0, 9))
      0: now_ns = now_ns - 64'($urandom_range(1, 100000));   // time steps back
      1: now_ns = now_ns + 64'($urandom_range(1000000000, 2000000000));
      2: now_ns = {$urandom, $urandom};
      3, 4: now_ns = now_ns + 64'($urandom_range(0, 1000));
      default: now_ns = now_ns + 64'($urandom_range(1000, 200000000));
    endcase
  endtask

  task automatic random_item(input int pool);
    logic [31:0] ip;
    int sel;
    advance_clock_ns();
    ip = POOL_BASE + 32'($urandom_range(0, pool - 1));
    sel = $urandom_range(0, 19);
    if (sel < 5)
      write_rule(ip, pick_rate(), ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom),
                 ($urandom_range(0, 1) == 0) ? 34'($urandom_range(0, 100000)) :
                 34'({$urandom, $urandom}));
    else if (sel < 17)
      send_packet(ip, 8'($urandom), pick_length());
    else if (sel == 17)
      send_packet({$urandom}, 8'($urandom), pick_length());
    else
      // header flag and version both random, so often malformed or not four
      transfer(1'b0, ip, now_ns, 1'($urandom), 4'($urandom), 8'($urandom), pick_length(),
               34'({$urandom, $urandom}), 6'($urandom), 34'({$urandom, $urandom}));
  endtask

  initial begin
    n_writes = 0; n_packets = 0; now_ns = 64'd5000;
    start = 1'b0; kind = 1'b0; client_ip = '0; timestamp_ns = '0;
    header_complete = 1'b0; ip_version = '0; tos_in = '0; packet_length = '0;
    rule_rate = '0; rule_dscp = '0; rule_tokens = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed cases
    send_packet(POOL_BASE, 8'h55, 16'd100);                  // empty table
    write_rule(32'h0000_0000, '0, 6'd0, '0);
    write_rule(32'hFFFF_FFFF, '1, 6'd63, '1);
    write_rule(32'h0000_0000, '0, 6'd46, 34'd10);            // update
    send_packet(32'h0000_0000, 8'hFF, 16'hFFFF);             // rate zero, remark
    send_packet(32'hFFFF_FFFF, 8'hFF, 16'd0);                // remark leaves tos alone
    send_packet(32'hFFFF_FFFF, 8'h00, 16'hFFFF);
    transfer(1'b0, 32'hFFFF_FFFF, now_ns, 1'b0, 4'd4, 8'h12, 16'd1, '0, '0, '0);
    transfer(1'b0, 32'hFFFF_FFFF, now_ns, 1'b1, 4'd6, 8'h12, 16'd1, '0, '0, '0);
    transfer(1'b0, 32'hFFFF_FFFF, now_ns, 1'b1, 4'd15, 8'h12, 16'd1, '0, '0, '0);
    write_rule(POOL_BASE, 34'd1000000, 6'd10, 34'd50000);
    send_packet(POOL_BASE, 8'h2B, 16'd40000);                // fits the bucket, passes
    send_packet(POOL_BASE, 8'h2B, 16'd50000);
    send_packet(POOL_BASE, 8'h01, 16'd1);
    now_ns = now_ns + 64'd3000000000;                        // longer than a second
    send_packet(POOL_BASE, 8'h00, 16'd49999);
    now_ns = now_ns - 64'd700;                               // time steps back
    send_packet(POOL_BASE, 8'h00, 16'd1);
    now_ns = 64'hFFFF_FFFF_FFFF_FFF0;
    send_packet(POOL_BASE, 8'h00, 16'd1);
    now_ns = 64'd20;                                         // wraps round
    send_packet(POOL_BASE, 8'h00, 16'd1);
    write_rule(POOL_BASE + 1, 34'd9, 6'd1, '1);              // burst of zero
    send_packet(POOL_BASE + 1, 8'h04, 16'd0);
    send_packet(POOL_BASE + 1, 8'h04, 16'd1);

    // random items over a small pool, with a full drain part way through
    for (int i = 0; i < 750; i++) begin
      if (i == 375) begin
        start = 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      random_item((i < 250) ? 4 : 16);
    end

    // fill the table; writes past capacity are refused
    for (int i = 0; i < pctbp_pkg::CLIENTS; i++) begin
      now_ns = now_ns + 64'($urandom_range(0, 1000000));
      write_rule(FILL_BASE + 32'(i), pick_rate(), 6'($urandom), 34'({$urandom, $urandom}));
    end
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 2) == 0)
        write_rule(FILL_BASE + 32'($urandom_range(0, 1023)), pick_rate(), 6'($urandom),
                   34'({$urandom, $urandom}));
      else random_item(16);
    end

    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    $display("covered %0d rule writes and %0d packets", n_writes, n_packets);
    $display("saw %0d drops, %0d remarks and %0d refused writes", drops, remarks, refusals);
    if (failures == 0 && outstanding == 0) begin
      $display("per_client_token_bucket_policer_tb OK");
    end else begin
      $display("per_client_token_bucket_policer_tb NOT OK");
    end
    $finish;
  end
endmodule
